### rtl/acg_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// AdaGrad embedding update block. No dependencies.
package acg_pkg;

  // Table geometry
  localparam int VOCAB   = 4096;
  localparam int DIM     = 64;
  localparam int ROW_LEN = 2 * DIM;
  localparam int DEPTH   = 2 * VOCAB * ROW_LEN;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int EL_W    = $clog2(DIM);
  localparam int CNT_W   = (ADDR_W > 6) ? ADDR_W : 6;

  // Iteration counts of the shared root and divide units
  localparam int SQRT_ITERS = 32;
  localparam int DIV_ITERS  = 34;

  // Item kinds
  localparam logic [1:0] KIND_GRAD  = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // Result kinds
  localparam logic RES_READ    = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VMIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VMAX  = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic              load;       // capture an accepted item
    logic              clr_wr;     // clear one history entry
    logic              rd_item;    // read both stores at the item address
    logic              rd_walk;    // read weight at row base + el
    logic              walk_sum;   // that read feeds the square sum
    logic              wr_item;    // direct weight write
    logic              out_read;   // present read data
    logic              out_sum;    // present row summary
    logic              g_latch;    // latch weight and history
    logic              mul_num;    // num = |g| * rate
    logic              mul_sq;     // g squared
    logic              rs_mul;     // num = |w| * limit
    logic              sqrt_init_g;
    logic              sqrt_init_n;
    logic              sqrt_step;
    logic              div_init_g;
    logic              div_init_r;
    logic              div_step;
    logic              upd;        // form new weight and history
    logic              wb;         // write back weight and history
    logic              sum_clr;
    logic              norm_latch;
    logic              rs_wb;      // write back rescaled weight
    logic [ADDR_W-1:0] idx;
    logic [EL_W-1:0]   el;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] kind;
    logic       ok;
    logic       last;
    logic       big_now;
  } sts_t;

endpackage

### rtl/adagrad_clipped_embedding_update.sv
// Top level of the AdaGrad embedding update block with gradient clipping.
// Depends on acg_pkg, acg_ctrl and acg_dp.
//
// After reset the block runs a clearing pass over the gradient history of
// DEPTH entries, one entry a cycle, with busy high; settings may be
// written during it. Items are taken when start is high and busy is low,
// one at a time. A read shows its result in the first cycle that busy is
// low. A gradient item runs the 32-step square root and the 34-step
// divider that it shares with the rescale. A gradient on the last mean
// element adds a walk of the DIM mean weights and a second root, and when
// the norm exceeds the limit a rescale of each mean element through the
// divider; the summary follows. Each result shows for one cycle on
// out_valid and cannot be held off by the receiver.
module adagrad_clipped_embedding_update (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_kind,
  input  logic                          in_table_select,
  input  logic [11:0]                   in_row,
  input  logic [6:0]                    in_element,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  output logic                          out_result_kind,
  output logic signed [31:0]            out_data,
  output logic [30:0]                   out_mean_norm,
  output logic                          out_rescaled,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  acg_pkg::cmd_t cmd;
  acg_pkg::sts_t sts;

  // Settings are always writable
  assign cfg_ready = 1'b1;

  acg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  acg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_kind         (in_kind),
    .in_table_select (in_table_select),
    .in_row          (in_row),
    .in_element      (in_element),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_data        (out_data),
    .out_mean_norm   (out_mean_norm),
    .out_rescaled    (out_rescaled)
  );

`ifndef SYNTH
  // A result only appears once the item is finished
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  // An accepted item occupies the block
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item accepted but not busy");

  // One item, one strobe
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
`endif

endmodule

### rtl/acg_ctrl.sv
// Sequencing state machine of the AdaGrad embedding update block.
// Depends on acg_pkg; drives acg_dp through acg_pkg::cmd_t.
module acg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  acg_pkg::sts_t sts,
  output acg_pkg::cmd_t cmd
);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_RDW  = 5'd3;
  localparam logic [4:0] S_GW   = 5'd4;
  localparam logic [4:0] S_GSQ  = 5'd5;
  localparam logic [4:0] S_GDI  = 5'd6;
  localparam logic [4:0] S_GDIV = 5'd7;
  localparam logic [4:0] S_GUPD = 5'd8;
  localparam logic [4:0] S_GWB  = 5'd9;
  localparam logic [4:0] S_NRD  = 5'd10;
  localparam logic [4:0] S_ND1  = 5'd11;
  localparam logic [4:0] S_ND2  = 5'd12;
  localparam logic [4:0] S_NSI  = 5'd13;
  localparam logic [4:0] S_NSQ  = 5'd14;
  localparam logic [4:0] S_NCHK = 5'd15;
  localparam logic [4:0] S_NOUT = 5'd16;
  localparam logic [4:0] S_RRD  = 5'd17;
  localparam logic [4:0] S_RMUL = 5'd18;
  localparam logic [4:0] S_RDI  = 5'd19;
  localparam logic [4:0] S_RDIV = 5'd20;
  localparam logic [4:0] S_RWB  = 5'd21;

  localparam logic [acg_pkg::CNT_W-1:0] CNT_CLR_END =
    acg_pkg::CNT_W'(acg_pkg::DEPTH - 1);
  localparam logic [acg_pkg::CNT_W-1:0] CNT_SQ_END =
    acg_pkg::CNT_W'(acg_pkg::SQRT_ITERS - 1);
  localparam logic [acg_pkg::CNT_W-1:0] CNT_DIV_END =
    acg_pkg::CNT_W'(acg_pkg::DIV_ITERS - 1);
  localparam logic [acg_pkg::EL_W-1:0] EL_END = acg_pkg::EL_W'(acg_pkg::DIM - 1);

  logic [4:0]                state_r, state_nxt;
  logic [acg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [acg_pkg::EL_W-1:0]  el_r, el_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    el_nxt    = el_r;
    cmd       = '0;
    cmd.idx   = cnt_r[acg_pkg::ADDR_W-1:0];
    cmd.el    = el_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (cnt_r == CNT_CLR_END) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (sts.kind)
          acg_pkg::KIND_READ: begin
            cmd.rd_item = sts.ok;
            state_nxt   = S_RDW;
          end
          acg_pkg::KIND_WRITE: begin
            cmd.wr_item = sts.ok;
          end
          acg_pkg::KIND_GRAD: begin
            if (sts.ok) begin
              cmd.rd_item = 1'b1;
              state_nxt   = S_GW;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RDW: begin
        cmd.out_read = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_GW: begin
        cmd.g_latch     = 1'b1;
        cmd.mul_num     = 1'b1;
        cmd.sqrt_init_g = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = S_GSQ;
      end
      S_GSQ: begin
        cmd.sqrt_step = 1'b1;
        cmd.mul_sq    = (cnt_r == '0);
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_SQ_END) state_nxt = S_GDI;
      end
      S_GDI: begin
        cmd.div_init_g = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = S_GDIV;
      end
      S_GDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_DIV_END) state_nxt = S_GUPD;
      end
      S_GUPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_GWB;
      end
      S_GWB: begin
        cmd.wb = 1'b1;
        if (sts.last) begin
          cmd.sum_clr = 1'b1;
          el_nxt      = '0;
          state_nxt   = S_NRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // Walk the mean half; each read weight is squared into sqw_r, then added to the sum
      S_NRD: begin
        cmd.rd_walk  = 1'b1;
        cmd.walk_sum = 1'b1;
        if (el_r == EL_END) state_nxt = S_ND1;
        else el_nxt = el_r + 1'b1;
      end
      S_ND1: state_nxt = S_ND2;
      S_ND2: state_nxt = S_NSI;
      S_NSI: begin
        cmd.sqrt_init_n = 1'b1;
        cnt_nxt         = '0;
        state_nxt       = S_NSQ;
      end
      S_NSQ: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_SQ_END) state_nxt = S_NCHK;
      end
      S_NCHK: begin
        cmd.norm_latch = 1'b1;
        el_nxt         = '0;
        state_nxt      = sts.big_now ? S_RRD : S_NOUT;
      end
      S_NOUT: begin
        cmd.out_sum = 1'b1;
        state_nxt   = S_IDLE;
      end
      // Rescale loop, one element at a time
      S_RRD: begin
        cmd.rd_walk = 1'b1;
        state_nxt   = S_RMUL;
      end
      S_RMUL: begin
        cmd.rs_mul = 1'b1;
        state_nxt  = S_RDI;
      end
      S_RDI: begin
        cmd.div_init_r = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = S_RDIV;
      end
      S_RDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_DIV_END) state_nxt = S_RWB;
      end
      S_RWB: begin
        cmd.rs_wb = 1'b1;
        if (el_r == EL_END) begin
          state_nxt = S_NOUT;
        end else begin
          el_nxt    = el_r + 1'b1;
          state_nxt = S_RRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      el_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      el_r    <= el_nxt;
    end
  end

endmodule

### rtl/acg_dp.sv
// Datapath of the AdaGrad embedding update block: weight and history stores,
// settings, shared multiplier, root and divide units. Depends on acg_pkg.
module acg_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  acg_pkg::cmd_t                   cmd,
  output acg_pkg::sts_t                   sts,
  input  logic                            cfg_we,
  input  logic [acg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic [1:0]                      in_kind,
  input  logic                            in_table_select,
  input  logic [11:0]                     in_row,
  input  logic [6:0]                      in_element,
  input  logic signed [31:0]              in_value,
  output logic                            out_valid,
  output logic                            out_result_kind,
  output logic signed [31:0]              out_data,
  output logic [30:0]                     out_mean_norm,
  output logic                            out_rescaled
);

  localparam int AW = acg_pkg::ADDR_W;
  localparam logic [33:0] STEP_CAP = 34'h2_0000_0000;
  localparam logic signed [35:0] W_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] W_MIN = -36'sh0_8000_0000;

  // Settings
  logic [30:0] rate_r, eps_r, vmin_r, vmax_r;
  logic [29:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r  <= 31'd16777216;
      eps_r   <= 31'd1677722;
      limit_r <= 30'd16777216;
      vmin_r  <= 31'd1677722;
      vmax_r  <= 31'd167772160;
    end else if (cfg_we) begin
      case (cfg_index)
        acg_pkg::CFG_RATE:  rate_r  <= cfg_data[30:0];
        acg_pkg::CFG_EPS:   eps_r   <= cfg_data[30:0];
        acg_pkg::CFG_LIMIT: limit_r <= cfg_data[29:0];
        acg_pkg::CFG_VMIN:  vmin_r  <= cfg_data[30:0];
        acg_pkg::CFG_VMAX:  vmax_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Item decode and gradient clip at capture
  logic               var_in, ok_in, last_in, gpos_in;
  logic [31:0]        base_in, m_in;
  logic signed [32:0] lim_in, v_in, g_in;

  always_comb begin
    var_in  = 32'(in_element) >= 32'(acg_pkg::DIM);
    last_in = 32'(in_element) == 32'(acg_pkg::DIM - 1);
    ok_in   = (32'(in_row) < 32'(acg_pkg::VOCAB)) &&
              (32'(in_element) < 32'(acg_pkg::ROW_LEN));
    base_in = (32'(in_table_select) * 32'(acg_pkg::VOCAB) + 32'(in_row)) *
              32'(acg_pkg::ROW_LEN);
    lim_in  = var_in ? $signed({2'b00, vmax_r}) : $signed({2'b00, limit_r, 1'b0});
    v_in    = {in_value[31], in_value};
    if (v_in > lim_in) g_in = lim_in;
    else if (v_in < -lim_in) g_in = -lim_in;
    else g_in = v_in;
    m_in    = g_in[32] ? 32'(-g_in) : g_in[31:0];
    gpos_in = !g_in[32] && (g_in != '0);
  end

  logic [1:0]         kind_r;
  logic               ok_r, var_r, last_r, gpos_r;
  logic [AW-1:0]      addr_r, base_r;
  logic [31:0]        val_r, m_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      ok_r   <= ok_in;
      var_r  <= var_in;
      last_r <= last_in;
      gpos_r <= gpos_in;
      base_r <= AW'(base_in);
      addr_r <= AW'(base_in + 32'(in_element));
      val_r  <= in_value;
      m_r    <= m_in;
    end
  end

  // Stores
  logic [31:0] wmem [acg_pkg::DEPTH];
  logic [39:0] hmem [acg_pkg::DEPTH];
  logic [31:0] wq_r;
  logic [39:0] hq_r;
  logic [AW-1:0] walk_addr, w_waddr, h_waddr;
  logic [31:0] w_wdata;
  logic [39:0] h_wdata;
  logic        w_we, h_we;

  assign walk_addr = base_r + AW'(cmd.el);

  always_ff @(posedge clk) begin
    if (cmd.rd_item || cmd.rd_walk) wq_r <= wmem[cmd.rd_walk ? walk_addr : addr_r];
    if (cmd.rd_item) hq_r <= hmem[addr_r];
    if (w_we) wmem[w_waddr] <= w_wdata;
    if (h_we) hmem[h_waddr] <= h_wdata;
  end

  // Shared multiplier
  logic [31:0] qmag, mul_a, mul_b;
  logic [63:0] mul_p;

  assign qmag = wq_r[31] ? 32'(-wq_r) : wq_r;

  always_comb begin
    if (cmd.rs_mul) begin
      mul_a = qmag;
      mul_b = {2'b00, limit_r};
    end else if (cmd.mul_num) begin
      mul_a = m_r;
      mul_b = {1'b0, rate_r};
    end else if (cmd.mul_sq) begin
      mul_a = m_r;
      mul_b = m_r;
    end else begin
      mul_a = qmag;
      mul_b = qmag;
    end
    mul_p = {32'b0, mul_a} * {32'b0, mul_b};
  end

  // Working registers
  logic [31:0] w_r, norm_r;
  logic [39:0] h_r;
  logic [63:0] num_r, sqg_r, sqw_r, sum_r;
  logic        sgn_r, big_r, rdv_r, sqv_r;

  // Bit-by-bit square root, one result bit per step
  logic [63:0] x_r, r_r, bit_r, sq_t;
  logic [40:0] s_g;

  assign s_g  = {1'b0, hq_r} + {10'b0, eps_r};
  assign sq_t = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init_g || cmd.sqrt_init_n) begin
      x_r   <= cmd.sqrt_init_g ? {1'b0, s_g, 22'b0} : sum_r;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if (x_r >= sq_t) begin
        x_r <= x_r - sq_t;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Restoring divider, quotient below 2^34
  logic [63:0] rem_r;
  logic [65:0] dsh_r;
  logic [33:0] q_r;
  logic        cap_r, numz_r;
  logic [32:0] den_g;

  assign den_g = {r_r[31:0], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init_g || cmd.div_init_r) begin
      rem_r <= num_r;
      q_r   <= '0;
      if (cmd.div_init_g) begin
        dsh_r  <= {den_g, 33'b0};
        numz_r <= (num_r == '0);
        cap_r  <= (num_r != '0) &&
                  ((r_r == '0) || ({3'b0, num_r} >= {den_g, 34'b0}));
      end else begin
        dsh_r  <= {1'b0, norm_r, 33'b0};
        numz_r <= 1'b0;
        cap_r  <= 1'b0;
      end
    end else if (cmd.div_step) begin
      if ({2'b0, rem_r} >= dsh_r) begin
        rem_r <= 64'({2'b0, rem_r} - dsh_r);
        q_r   <= {q_r[32:0], 1'b1};
      end else begin
        q_r   <= {q_r[32:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  // Weight step and history accumulate
  logic [33:0]        stepv;
  logic signed [35:0] wn;
  logic [40:0]        hs;
  logic [31:0]        wc;

  always_comb begin
    if (numz_r) stepv = '0;
    else if (cap_r || (q_r > STEP_CAP)) stepv = STEP_CAP;
    else stepv = q_r;
    wn = gpos_r ? ($signed({{4{w_r[31]}}, w_r}) - $signed({2'b00, stepv}))
                : ($signed({{4{w_r[31]}}, w_r}) + $signed({2'b00, stepv}));
    hs = {1'b0, h_r} + {3'b0, sqg_r[61:24]};
    // Variance clamp: upper bound first
    wc = w_r;
    if (var_r) begin
      if ($signed(w_r) > $signed({1'b0, vmax_r})) wc = {1'b0, vmax_r};
      else if ($signed(w_r) < $signed({1'b0, vmin_r})) wc = {1'b0, vmin_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.g_latch) begin
      w_r <= wq_r;
      h_r <= hq_r;
    end else if (cmd.upd) begin
      if (wn > W_MAX) w_r <= 32'h7FFF_FFFF;
      else if (wn < W_MIN) w_r <= 32'h8000_0000;
      else w_r <= wn[31:0];
      h_r <= hs[40] ? 40'hFF_FFFF_FFFF : hs[39:0];
    end
    if (cmd.mul_num || cmd.rs_mul) num_r <= mul_p;
    if (cmd.mul_sq) sqg_r <= mul_p;
    if (cmd.rs_mul) sgn_r <= wq_r[31];
    if (rdv_r) sqw_r <= mul_p;
    if (cmd.norm_latch) begin
      norm_r <= r_r[31:0];
      big_r  <= r_r[31:0] > {2'b00, limit_r};
    end
  end

  // Square sum of the mean half, saturating
  logic [64:0] sum_add;
  assign sum_add = {1'b0, sum_r} + {1'b0, sqw_r};

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) sum_r <= '0;
    else if (sqv_r) sum_r <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
      sqv_r <= 1'b0;
    end else begin
      rdv_r <= cmd.walk_sum;
      sqv_r <= rdv_r;
    end
  end

  // Store write ports
  always_comb begin
    w_we    = cmd.wr_item || cmd.wb || cmd.rs_wb;
    w_waddr = cmd.rs_wb ? walk_addr : addr_r;
    if (cmd.rs_wb) w_wdata = sgn_r ? 32'(-q_r[31:0]) : q_r[31:0];
    else if (cmd.wb) w_wdata = wc;
    else w_wdata = val_r;
    h_we    = cmd.clr_wr || cmd.wb;
    h_waddr = cmd.clr_wr ? cmd.idx : addr_r;
    h_wdata = cmd.clr_wr ? '0 : h_r;
  end

  // Result register
  logic               ov_r, ork_r, orsc_r;
  logic signed [31:0] odata_r;
  logic [30:0]        onorm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else ov_r <= cmd.out_read || cmd.out_sum;
    if (cmd.out_read) begin
      ork_r   <= acg_pkg::RES_READ;
      odata_r <= ok_r ? wq_r : '0;
      onorm_r <= '0;
      orsc_r  <= 1'b0;
    end else if (cmd.out_sum) begin
      ork_r   <= acg_pkg::RES_SUMMARY;
      odata_r <= '0;
      onorm_r <= norm_r[31] ? 31'h7FFF_FFFF : norm_r[30:0];
      orsc_r  <= big_r;
    end
  end

  assign out_valid       = ov_r;
  assign out_result_kind = ork_r;
  assign out_data        = odata_r;
  assign out_mean_norm   = onorm_r;
  assign out_rescaled    = orsc_r;

  assign sts.kind    = kind_r;
  assign sts.ok      = ok_r;
  assign sts.last    = last_r;
  assign sts.big_now = r_r[31:0] > {2'b00, limit_r};

endmodule
